[hw/rtl/smf_pkg.sv]
// Shared types, constants and helper functions of the running median filter.
package smf_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 5;
    localparam int RESET_LEN  = 5;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [LEN_W-1:0]    t_len;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANK,
        ST_PUB
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // store the incoming sample and restart the rank walk
        logic rank;     // rank the current candidate and step to the next one
        logic publish;  // move the captured median into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_cand;  // the current candidate is the last active entry
        logic out_free;   // the output register can take a new word
    } t_stat;

    // Register value clamped to the lengths the window supports.
    function automatic t_len eff_len(input logic [CFG_W-1:0] value);
        t_len result;
        if (value == '0) begin
            result = t_len'(1);
        end else if (int'(value) > MAX_WINDOW) begin
            result = t_len'(MAX_WINDOW);
        end else begin
            result = t_len'(value);
        end
        return result;
    endfunction

endpackage

[hw/rtl/smf_ctrl.sv]
// Controller state machine of the running median filter.
module smf_ctrl
    import smf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RANK;
                end
            end
            ST_RANK: begin
                if (i_stat.last_cand) begin
                    n_state = ST_PUB;
                end
            end
            ST_PUB: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_RANK: begin
                o_cmd.rank = 1'b1;
            end
            ST_PUB: begin
                o_cmd.publish = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A word is only taken in while no other one is being ranked.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> (r_state == ST_IDLE))
        else $error("sample accepted outside idle");

    // The rank walk always follows an accepted word.
    a_accept_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == ST_RANK))
        else $error("rank walk did not start after accept");

    // Publishing never overwrites a word the sink has not taken.
    a_pub_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> i_stat.out_free)
        else $error("publish while output register busy");
`endif

endmodule

[hw/rtl/smf_datapath.sv]
// Datapath of the running median filter: window, rank unit and output register.
module smf_datapath
    import smf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  t_sample          i_sample,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_sample          o_out_median,
    output logic             o_out_full
);

    t_sample r_win [MAX_WINDOW];
    t_idx    r_wpos;
    logic    r_full;
    t_len    r_len;
    t_idx    r_idx;
    t_sample r_med;
    logic    r_out_valid;
    t_sample r_out_median;
    logic    r_out_full;

    t_sample         w_cand;
    logic [MAX_WINDOW-1:0] w_less;
    t_len            w_rank;
    t_len            w_next_pos;

    assign w_cand     = r_win[r_idx];
    assign w_next_pos = t_len'(r_wpos) + t_len'(1);

    // An entry ranks below the candidate if it is smaller, or equal and earlier,
    // so every active entry gets a distinct rank.
    always_comb begin
        for (int j = 0; j < MAX_WINDOW; j++) begin
            w_less[j] = (t_len'(j) < r_len) &&
                        ((r_win[j] < w_cand) ||
                         ((r_win[j] == w_cand) && (t_idx'(j) < r_idx)));
        end
    end

    assign w_rank = t_len'($countones(w_less));

    assign o_stat.last_cand = (t_len'(r_idx) == (r_len - t_len'(1)));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int j = 0; j < MAX_WINDOW; j++) begin
                r_win[j] <= '0;
            end
            r_wpos <= '0;
            r_full <= 1'b0;
        end else if (i_cmd.accept) begin
            r_win[r_wpos] <= i_sample;
            if (w_next_pos >= r_len) begin
                r_wpos <= '0;
                r_full <= 1'b1;
            end else begin
                r_wpos <= t_idx'(w_next_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= t_len'(RESET_LEN);
        end else if (i_cfg_we) begin
            r_len <= eff_len(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= '0;
        end else if (i_cmd.rank) begin
            r_idx <= r_idx + t_idx'(1);
        end
        if (i_cmd.rank && (w_rank == (r_len >> 1))) begin
            r_med <= w_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_median <= r_med;
            r_out_full   <= r_full;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_median = r_out_median;
    assign o_out_full   = r_out_full;

`ifndef NO_ASSERTIONS
    // The write position stays inside the active window.
    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_len'(r_wpos) < r_len)
        else $error("write position outside the window");

    // The full flag only drops on reset or when the length is rewritten.
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !i_cfg_we) |=> r_full)
        else $error("full flag dropped without a length write");

    // A word waiting at the output is not replaced before it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_median)))
        else $error("pending output word changed");
`endif

endmodule

[hw/rtl/sliding_window_median_filter_core.sv]
// Top level of the running median filter: controller and datapath joined.
//
// Each 16-bit sample overwrites the oldest entry of a circular window of
// window_len entries (1 to 16; 0 acts as 1, larger values as 16) and yields
// one output word: the element at index window_len/2 of the sorted window,
// with tuser high once the window has wrapped. Entries never written count
// as zero. Each sample is first stored, then the rank unit compares every
// active entry in turn against the whole window, and then the median is
// loaded into the output register once that register is free. Further
// samples wait until then, but a new sample is taken in while the previous
// word still waits at the output. Writing window_len clears the window and
// the flag; it is meant to be written only while the block is idle.
module sliding_window_median_filter_core
    import smf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [15:0] sample
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] median
    output logic             m_axis_tuser,   // [0] window_full
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data      // [4:0] window_len
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;

    smf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    smf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_sample     (s_axis_tdata),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_median (m_axis_tdata),
        .o_out_full   (m_axis_tuser)
    );

endmodule
